>>> hdl/mbsr_pkg.sv
package mbsr_pkg;

    localparam int MAX_BUFFER_LEN = 64;
    localparam int MAX_RINGS      = 8;
    localparam int SAMPLE_WIDTH   = 16;

    localparam int POS_W  = $clog2(MAX_BUFFER_LEN);
    localparam int PTR_W  = 3;
    localparam int LEN_W  = 7;
    localparam int RL_W   = 4;
    localparam int CNT_W  = 9;
    localparam int ADDR_W = PTR_W + POS_W;
    localparam int DEPTH  = MAX_RINGS * MAX_BUFFER_LEN;

    localparam int S_TDATA_W = 32;
    localparam int M_WORD_W  = 55;
    localparam int M_TDATA_W = 56;

    localparam logic CFG_BUFFER_LENGTH = 1'b0;
    localparam logic CFG_RING_LENGTH   = 1'b1;

    localparam logic [LEN_W-1:0] BL_RESET = LEN_W'(MAX_BUFFER_LEN);
    localparam logic [RL_W-1:0]  RL_RESET = RL_W'(MAX_RINGS);
    localparam logic [CNT_W-1:0] TW_RESET = CNT_W'((MAX_RINGS - 1) * MAX_BUFFER_LEN);

    typedef enum logic [2:0] {
        MODE_WRITE      = 3'd0,
        MODE_READ       = 3'd1,
        MODE_ROT_READ   = 3'd2,
        MODE_ROT_WRITE  = 3'd3,
        MODE_ROT_PROC   = 3'd4,
        MODE_RESET      = 3'd5,
        MODE_QUERY_FLAG = 3'd6,
        MODE_SET_FLAG   = 3'd7
    } mode_t;

    function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] p,
                                                  input logic [RL_W-1:0] rl);
        logic [RL_W-1:0] n;
        n = RL_W'(p) + RL_W'(1);
        return (n >= rl) ? '0 : n[PTR_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sub_clamp(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0] a,
                                                 input logic [LEN_W-1:0] b,
                                                 input logic [CNT_W-1:0] tw);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W+1)'(b);
        return (s > {1'b0, tw}) ? tw : s[CNT_W-1:0];
    endfunction

endpackage

>>> hdl/multi_buffer_sample_ring.sv
// ring of equal sample buffers with read, write and processing pointers
// input items arrive on s_axis (tuser carries the mode), results leave on m_axis
// every item yields one result, except a buffer read, which yields one result
// per sample of the read buffer with tlast on the final one
// non-read items are taken one per cycle while the output is free; the result
// appears in the cycle after accept; a buffer read first starts the sample memory,
// then streams buffer_length samples from its read port at one per cycle while the
// receiver takes them, and holds off new items until its final sample is loaded
// into the output register; a new item is taken in the same cycle the waiting result
// leaves, so items follow back to back while the receiver keeps m_tready high; when
// the receiver stalls, results hold and the read stream pauses without loss
// sample storage is one 512 x 16 memory; each buffer keeps a high-water mark of
// written positions, so reset, a wiping reset item and configuration writes clear
// it at once: positions not below the mark read as zero; no clearing pass is needed
// aresetn (synchronous, active low) restores 64 samples per buffer, 8 buffers
// and the initial pointers; a configuration write also resets the ring state
module multi_buffer_sample_ring (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [mbsr_pkg::LEN_W-1:0]       cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // sample[15:0], force_req[16], initial_req[17], length[24:18],
    // ring_index[27:25], flag_value[28], wipe[29]
    input  logic [mbsr_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[2:0]
    input  logic [2:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sample_out[15:0], accepted[16], buffered_count[25:17],
    // available_count[34:26], processed_count[43:35], read_pointer[46:44],
    // write_pointer[49:47], process_pointer[52:50], flag_out[53], writable[54]
    output logic [mbsr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);
    import mbsr_pkg::*;

    logic [LEN_W-1:0]  bl_reg;
    logic [RL_W-1:0]   rl_reg;
    logic [CNT_W-1:0]  tw_reg;

    logic [PTR_W-1:0]  rp_reg, wp_reg, pp_reg, rb_reg;
    logic [LEN_W-1:0]  fp_reg;
    logic [CNT_W-1:0]  bt_reg, pt_reg;
    logic [MAX_RINGS-1:0] flags_reg;
    logic [LEN_W-1:0]  hw_reg [MAX_RINGS];

    logic [PTR_W-1:0]  rp_next, wp_next, pp_next, rb_next;
    logic [LEN_W-1:0]  fp_next;
    logic [CNT_W-1:0]  bt_next, pt_next;
    logic [MAX_RINGS-1:0] flags_next;
    logic [LEN_W-1:0]  hw_next [MAX_RINGS];

    logic              busy_reg;
    logic [LEN_W-1:0]  k_reg;
    logic [M_WORD_W-1:0] rd_word_reg;
    logic              m_valid_reg;
    logic [M_WORD_W-1:0] m_word_reg;
    logic              m_last_reg;

    logic [SAMPLE_WIDTH-1:0] mem [DEPTH];
    logic [SAMPLE_WIDTH-1:0] mem_q;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;

    mode_t             mode;
    logic [SAMPLE_WIDTH-1:0] in_sample;
    logic              in_force, in_initial, in_flag_value, in_wipe;
    logic [LEN_W-1:0]  in_length, len_sat;
    logic [PTR_W-1:0]  in_ring_index;

    logic              item_acc, out_free, rd_load, rd_last;
    logic              acc_bit, flag_bit;
    logic [M_WORD_W-1:0] item_word;
    logic [LEN_W-1:0]  k_inc;
    logic [SAMPLE_WIDTH-1:0] rd_sample;
    logic [LEN_W-1:0]  cfg_bl, cfg_rl7;
    logic [RL_W-1:0]   cfg_rl;

    assign mode          = mode_t'(s_tuser);
    assign in_sample     = s_tdata[15:0];
    assign in_force      = s_tdata[16];
    assign in_initial    = s_tdata[17];
    assign in_length     = s_tdata[24:18];
    assign in_ring_index = s_tdata[27:25];
    assign in_flag_value = s_tdata[28];
    assign in_wipe       = s_tdata[29];
    assign len_sat       = (in_length > bl_reg) ? bl_reg : in_length;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !busy_reg && out_free;
    assign item_acc = s_tvalid && s_tready;
    assign rd_load  = busy_reg && out_free;
    assign k_inc    = k_reg + LEN_W'(1);
    assign rd_last  = (k_inc == bl_reg);

    always_comb begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        pp_next    = pp_reg;
        fp_next    = fp_reg;
        bt_next    = bt_reg;
        pt_next    = pt_reg;
        flags_next = flags_reg;
        hw_next    = hw_reg;
        rb_next    = rp_reg;
        mem_we     = 1'b0;
        mem_waddr  = {wp_reg, fp_reg[POS_W-1:0]};
        acc_bit    = 1'b0;
        flag_bit   = 1'b0;
        unique case (mode)
            MODE_WRITE: begin
                if (in_initial) begin
                    pp_next = ring_adv(pp_reg, rl_reg);
                end
                if (rp_reg != wp_reg || in_force) begin
                    mem_we  = item_acc;
                    fp_next = fp_reg + LEN_W'(1);
                    if (fp_next > hw_reg[wp_reg]) begin
                        hw_next[wp_reg] = fp_next;
                    end
                    if (fp_next >= bl_reg) begin
                        wp_next = ring_adv(wp_reg, rl_reg);
                        fp_next = '0;
                        bt_next = add_sat(bt_reg, bl_reg, tw_reg);
                        flags_next[wp_next] = 1'b0;
                    end
                    acc_bit = 1'b1;
                end
            end
            MODE_READ, MODE_ROT_READ: begin
                if (mode == MODE_READ && in_initial) begin
                    rp_next = ring_adv(rp_reg, rl_reg);
                end
                rb_next = rp_next;
                rp_next = ring_adv(rp_next, rl_reg);
                bt_next = sub_clamp(bt_reg,
                    CNT_W'((mode == MODE_READ) ? bl_reg : len_sat));
                pt_next = sub_clamp(pt_reg,
                    CNT_W'((mode == MODE_READ) ? bl_reg : len_sat));
                if (in_force && rp_next == wp_reg) begin
                    wp_next = ring_adv(wp_reg, rl_reg);
                    fp_next = '0;
                    bt_next = add_sat(bt_next, bl_reg, tw_reg);
                    flags_next[wp_next] = 1'b0;
                end
            end
            MODE_ROT_WRITE: begin
                wp_next = ring_adv(wp_reg, rl_reg);
                fp_next = '0;
                bt_next = add_sat(bt_reg, len_sat, tw_reg);
                flags_next[wp_next] = 1'b0;
                if (in_force && rp_reg == wp_next) begin
                    rp_next = ring_adv(rp_reg, rl_reg);
                    bt_next = sub_clamp(bt_next, CNT_W'(bl_reg));
                    pt_next = sub_clamp(pt_reg, CNT_W'(bl_reg));
                end
            end
            MODE_ROT_PROC: begin
                flags_next[pp_reg] = 1'b1;
                pt_next = add_sat(pt_reg, len_sat, tw_reg);
                pp_next = ring_adv(pp_reg, rl_reg);
            end
            MODE_RESET: begin
                rp_next    = '0;
                wp_next    = PTR_W'(1);
                pp_next    = '0;
                fp_next    = '0;
                bt_next    = '0;
                pt_next    = '0;
                flags_next = '0;
                if (in_wipe) begin
                    for (int i = 0; i < MAX_RINGS; i++) begin
                        hw_next[i] = '0;
                    end
                end
            end
            MODE_QUERY_FLAG: begin
                if (RL_W'(in_ring_index) < rl_reg) begin
                    flag_bit = flags_reg[in_ring_index];
                end
            end
            MODE_SET_FLAG: begin
                if (RL_W'(in_ring_index) < rl_reg) begin
                    flags_next[in_ring_index] = in_flag_value;
                end
            end
            default: begin
            end
        endcase
    end

    assign item_word = {(rp_next != wp_next), flag_bit, pp_next, wp_next, rp_next,
                        pt_next, sub_clamp(tw_reg, bt_next), bt_next, acc_bit,
                        SAMPLE_WIDTH'(0)};

    always_comb begin
        if (busy_reg) begin
            mem_raddr = {rb_reg, (rd_load ? k_inc[POS_W-1:0] : k_reg[POS_W-1:0])};
        end else begin
            mem_raddr = {rb_next, POS_W'(0)};
        end
    end

    assign rd_sample = (k_reg < hw_reg[rb_reg]) ? mem_q : '0;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= in_sample;
        end
        mem_q <= mem[mem_raddr];
    end

    assign cfg_rl7 = LEN_W'(cfg_wr_data[RL_W-1:0]);
    assign cfg_bl  = (cfg_wr_data == '0) ? LEN_W'(1) :
                     (cfg_wr_data > BL_RESET) ? BL_RESET : cfg_wr_data;
    assign cfg_rl  = (cfg_rl7 < LEN_W'(2)) ? RL_W'(2) :
                     (cfg_rl7 > LEN_W'(RL_RESET)) ? RL_RESET : cfg_rl7[RL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            if (!aresetn) begin
                bl_reg <= BL_RESET;
                rl_reg <= RL_RESET;
                tw_reg <= TW_RESET;
            end else if (cfg_index == CFG_BUFFER_LENGTH) begin
                bl_reg <= cfg_bl;
                tw_reg <= CNT_W'(rl_reg - RL_W'(1)) * CNT_W'(cfg_bl);
            end else begin
                rl_reg <= cfg_rl;
                tw_reg <= CNT_W'(cfg_rl - RL_W'(1)) * CNT_W'(bl_reg);
            end
            rp_reg    <= '0;
            wp_reg    <= PTR_W'(1);
            pp_reg    <= '0;
            fp_reg    <= '0;
            bt_reg    <= '0;
            pt_reg    <= '0;
            flags_reg <= '0;
            for (int i = 0; i < MAX_RINGS; i++) begin
                hw_reg[i] <= '0;
            end
        end else if (item_acc) begin
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            pp_reg    <= pp_next;
            fp_reg    <= fp_next;
            bt_reg    <= bt_next;
            pt_reg    <= pt_next;
            flags_reg <= flags_next;
            hw_reg    <= hw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (item_acc) begin
            if (mode == MODE_READ) begin
                busy_reg    <= 1'b1;
                m_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (rd_load) begin
            m_valid_reg <= 1'b1;
            if (rd_last) begin
                busy_reg <= 1'b0;
            end
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_acc) begin
            k_reg       <= '0;
            rb_reg      <= rb_next;
            rd_word_reg <= item_word;
            m_word_reg  <= item_word;
            m_last_reg  <= 1'b1;
        end else if (rd_load) begin
            k_reg      <= k_inc;
            m_word_reg <= {rd_word_reg[M_WORD_W-1:SAMPLE_WIDTH], rd_sample};
            m_last_reg <= rd_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_word_reg};
    assign m_tlast  = m_last_reg;

endmodule
